[hdl/pcg32_pkg.sv]
// shared types, constants and output function of the pcg32 generator
package pcg32_pkg;

   localparam int unsigned STATE_W     = 64;
   localparam int unsigned HALF_W      = 32;
   localparam int unsigned VALUE_W     = 32;
   localparam int unsigned SEQ_W       = 63;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned CSR_DATA_W  = 63;
   localparam int unsigned COUNT_W     = 5;

   localparam logic [STATE_W-1:0] DEFAULT_STATE  = 64'h853c_49e6_748f_ea9b;
   localparam logic [STATE_W-1:0] DEFAULT_STREAM = 64'hda3e_39cb_94b9_5bdb;
   localparam logic [STATE_W-1:0] MULTIPLIER     = 64'h5851_f42d_4c95_7f2d;

   localparam logic [CSR_INDEX_W-1:0] REG_STREAM_MODE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SEQUENCE_INDEX = 2'd1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_CROSS_HI,
      ST_MUL_CROSS_LO,
      ST_SEED_ADD,
      ST_DIV_THRESH,
      ST_CHECK,
      ST_DIV_REM,
      ST_RESULT
   } state_type;

   typedef enum logic [1:0] {
      DRAW_SEED_FIRST,
      DRAW_SEED_SECOND,
      DRAW_REQUEST
   } draw_kind_type;

   // xorshift high then rotate right by the top five bits
   function automatic logic [VALUE_W-1:0] xsh_rr(input logic [STATE_W-1:0] prev);
      logic [STATE_W-1:0] mix_wide;
      logic [VALUE_W-1:0] mixed;
      logic [4:0]         rot;
      logic [2*VALUE_W-1:0] doubled;
      mix_wide = ((prev >> 18) ^ prev) >> 27;
      mixed    = mix_wide[VALUE_W-1:0];
      rot      = prev[63:59];
      doubled  = {mixed, mixed} >> rot;
      return doubled[VALUE_W-1:0];
   endfunction

endpackage

[hdl/pcg32_random_generator.sv]
// top level of the pcg32 xsh-rr generator with bounded draws
// One request is taken at a time. A draw uses a single 32x32 multiplier three times
// to advance the 64-bit state. A zero limit skips the remainder unit. A nonzero
// limit first runs a bit-serial remainder unit for the rejection threshold, then
// draws, and then runs the same unit again for the final remainder; each rejected
// draw adds another draw. After reset the default state and stream are loaded at
// once. A register write with stream mode 1 reseeds through two discarded draws,
// during which requests and writes are held off; the result register lets a
// finished value wait while the next request is taken.
module pcg32_random_generator (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [pcg32_pkg::VALUE_W-1:0]         req_limit,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [pcg32_pkg::VALUE_W-1:0]         rsp_value,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pcg32_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [pcg32_pkg::CSR_DATA_W-1:0]      csr_wdata
);
   import pcg32_pkg::*;

   state_type             state_ff, state_in;
   draw_kind_type         kind_ff, kind_in;
   logic                  mode_ff, mode_in;
   logic [SEQ_W-1:0]      seq_ff, seq_in;
   logic [STATE_W-1:0]    gen_ff, gen_in;
   logic [STATE_W-1:0]    inc_ff, inc_in;
   logic [STATE_W-1:0]    acc_ff, acc_in;
   logic [VALUE_W-1:0]    draw_ff, draw_in;
   logic [VALUE_W-1:0]    limit_ff, limit_in;
   logic [VALUE_W-1:0]    thresh_ff, thresh_in;
   logic [VALUE_W-1:0]    rem_ff, rem_in;
   logic [VALUE_W-1:0]    dvd_ff, dvd_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]    rsp_value_ff, rsp_value_in;

   logic [HALF_W-1:0]     mul_a, mul_b;
   logic [STATE_W-1:0]    mul_prod;
   logic [VALUE_W:0]      div_shift, div_diff;
   logic [VALUE_W-1:0]    div_next;
   logic                  out_free;
   logic                  cfg_write, req_take;
   logic                  new_mode;
   logic [SEQ_W-1:0]      new_seq;

   // shared multiplier
   always_comb begin
      mul_a = (state_ff == ST_MUL_CROSS_HI) ? gen_ff[63:32] : gen_ff[31:0];
      mul_b = (state_ff == ST_MUL_CROSS_LO) ? MULTIPLIER[63:32] : MULTIPLIER[31:0];
   end
   assign mul_prod = STATE_W'(mul_a) * STATE_W'(mul_b);

   // shared restoring remainder step
   assign div_shift = {rem_ff, dvd_ff[VALUE_W-1]};
   assign div_diff  = div_shift - {1'b0, limit_ff};
   assign div_next  = div_diff[VALUE_W] ? div_shift[VALUE_W-1:0] : div_diff[VALUE_W-1:0];

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_ready = (state_ff == ST_IDLE) && !csr_valid;
   assign cfg_write = csr_valid && csr_ready;
   assign req_take  = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;

   assign new_mode = (csr_index == REG_STREAM_MODE) ? csr_wdata[0] : mode_ff;
   assign new_seq  = (csr_index == REG_SEQUENCE_INDEX) ? csr_wdata : seq_ff;

   always_comb begin
      state_in     = state_ff;
      kind_in      = kind_ff;
      mode_in      = mode_ff;
      seq_in       = seq_ff;
      gen_in       = gen_ff;
      inc_in       = inc_ff;
      acc_in       = acc_ff;
      draw_in      = draw_ff;
      limit_in     = limit_ff;
      thresh_in    = thresh_ff;
      rem_in       = rem_ff;
      dvd_in       = dvd_ff;
      count_in     = count_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      case (state_ff)
         ST_IDLE: begin
            if (cfg_write) begin
               if (csr_index == REG_STREAM_MODE || csr_index == REG_SEQUENCE_INDEX) begin
                  mode_in = new_mode;
                  seq_in  = new_seq;
                  if (new_mode) begin
                     gen_in   = '0;
                     inc_in   = {new_seq, 1'b1};
                     kind_in  = DRAW_SEED_FIRST;
                     state_in = ST_MUL_LO;
                  end else begin
                     gen_in = DEFAULT_STATE;
                     inc_in = DEFAULT_STREAM;
                  end
               end
            end else if (req_take) begin
               limit_in = req_limit;
               kind_in  = DRAW_REQUEST;
               if (req_limit == '0) begin
                  state_in = ST_MUL_LO;
               end else begin
                  rem_in   = '0;
                  dvd_in   = '0 - req_limit;
                  count_in = '0;
                  state_in = ST_DIV_THRESH;
               end
            end
         end
         ST_MUL_LO: begin
            draw_in  = xsh_rr(gen_ff);
            acc_in   = mul_prod + inc_ff;
            state_in = ST_MUL_CROSS_HI;
         end
         ST_MUL_CROSS_HI: begin
            acc_in[63:32] = acc_ff[63:32] + mul_prod[31:0];
            state_in      = ST_MUL_CROSS_LO;
         end
         ST_MUL_CROSS_LO: begin
            gen_in = {acc_ff[63:32] + mul_prod[31:0], acc_ff[31:0]};
            case (kind_ff)
               DRAW_SEED_FIRST:  state_in = ST_SEED_ADD;
               DRAW_SEED_SECOND: state_in = ST_IDLE;
               DRAW_REQUEST:     state_in = ST_CHECK;
               default:          state_in = ST_IDLE;
            endcase
         end
         ST_SEED_ADD: begin
            gen_in   = gen_ff + DEFAULT_STATE;
            kind_in  = DRAW_SEED_SECOND;
            state_in = ST_MUL_LO;
         end
         ST_DIV_THRESH: begin
            rem_in   = div_next;
            dvd_in   = dvd_ff << 1;
            count_in = count_ff + COUNT_W'(1);
            if (count_ff == '1) begin
               thresh_in = div_next;
               state_in  = ST_MUL_LO;
            end
         end
         ST_CHECK: begin
            if (limit_ff == '0) begin
               rem_in   = draw_ff;
               state_in = ST_RESULT;
            end else if (draw_ff >= thresh_ff) begin
               rem_in   = '0;
               dvd_in   = draw_ff;
               count_in = '0;
               state_in = ST_DIV_REM;
            end else begin
               state_in = ST_MUL_LO;
            end
         end
         ST_DIV_REM: begin
            rem_in   = div_next;
            dvd_in   = dvd_ff << 1;
            count_in = count_ff + COUNT_W'(1);
            if (count_ff == '1) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rem_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kind_ff      <= DRAW_REQUEST;
         mode_ff      <= 1'b0;
         seq_ff       <= '0;
         gen_ff       <= DEFAULT_STATE;
         inc_ff       <= DEFAULT_STREAM;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kind_ff      <= kind_in;
         mode_ff      <= mode_in;
         seq_ff       <= seq_in;
         gen_ff       <= gen_in;
         inc_ff       <= inc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath, no reset
   always_ff @(posedge clock) begin
      acc_ff       <= acc_in;
      draw_ff      <= draw_in;
      limit_ff     <= limit_in;
      thresh_ff    <= thresh_in;
      rem_ff       <= rem_in;
      dvd_ff       <= dvd_in;
      count_ff     <= count_in;
      rsp_value_ff <= rsp_value_in;
   end

endmodule
